// ----- src/mvt_pkg.sv -----
`timescale 1ns / 1ps
package mvt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ROWS      = 4;
   localparam int COLS      = 4;
   localparam int NUM_WORDS = 8;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int WORD_W    = 64;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [WORD_W-1:0]        word_type;

   typedef data_type vec_type    [COLS];
   typedef data_type row_type    [ROWS];
   typedef data_type matrix_type [ROWS][COLS];
   typedef prod_type prod_arr_type [ROWS][COLS];
   typedef pair_type pair_arr_type [ROWS][2];
   typedef sum_type  sum_arr_type  [ROWS];

   // register map, one index per configuration word
   typedef enum logic [2:0] {
      CSR_COL0_ROWS01 = 3'd0,
      CSR_COL0_ROWS23 = 3'd1,
      CSR_COL1_ROWS01 = 3'd2,
      CSR_COL1_ROWS23 = 3'd3,
      CSR_COL2_ROWS01 = 3'd4,
      CSR_COL2_ROWS23 = 3'd5,
      CSR_COL3_ROWS01 = 3'd6,
      CSR_COL3_ROWS23 = 3'd7
   } csr_index_type;

endpackage

// ----- src/mvt_csr.sv -----
`timescale 1ns / 1ps
module mvt_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  mvt_pkg::csr_index_type wr_index,
   input  mvt_pkg::word_type     wr_data,
   output mvt_pkg::matrix_type   matrix
);

   mvt_pkg::word_type words_ff [mvt_pkg::NUM_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mvt_pkg::NUM_WORDS; i++) words_ff[i] <= '0;
      end else if (wr_en) begin
         unique case (wr_index)
            mvt_pkg::CSR_COL0_ROWS01: words_ff[0] <= wr_data;
            mvt_pkg::CSR_COL0_ROWS23: words_ff[1] <= wr_data;
            mvt_pkg::CSR_COL1_ROWS01: words_ff[2] <= wr_data;
            mvt_pkg::CSR_COL1_ROWS23: words_ff[3] <= wr_data;
            mvt_pkg::CSR_COL2_ROWS01: words_ff[4] <= wr_data;
            mvt_pkg::CSR_COL2_ROWS23: words_ff[5] <= wr_data;
            mvt_pkg::CSR_COL3_ROWS01: words_ff[6] <= wr_data;
            mvt_pkg::CSR_COL3_ROWS23: words_ff[7] <= wr_data;
         endcase
      end
   end

   // column c, row r lives in word 2c + r/2, half r%2
   always_comb begin
      for (int c = 0; c < mvt_pkg::COLS; c++) begin
         matrix[0][c] = words_ff[2*c][31:0];
         matrix[1][c] = words_ff[2*c][63:32];
         matrix[2][c] = words_ff[2*c+1][31:0];
         matrix[3][c] = words_ff[2*c+1][63:32];
      end
   end

endmodule

// ----- src/mvt_mul_stage.sv -----
`timescale 1ns / 1ps
module mvt_mul_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mvt_pkg::vec_type      vec,
   input  mvt_pkg::matrix_type   matrix,
   output logic                  out_valid,
   output mvt_pkg::prod_arr_type prod
);

   mvt_pkg::prod_arr_type prod_ff;
   mvt_pkg::prod_arr_type prod_in;
   logic                  valid_ff;

   // sixteen 32x32 signed products, one per matrix entry
   always_comb begin
      for (int r = 0; r < mvt_pkg::ROWS; r++) begin
         for (int c = 0; c < mvt_pkg::COLS; c++) begin
            prod_in[r][c] = mvt_pkg::prod_type'(matrix[r][c])
                          * mvt_pkg::prod_type'(vec[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

// ----- src/mvt_add_tree.sv -----
`timescale 1ns / 1ps
module mvt_add_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mvt_pkg::prod_arr_type prod,
   output logic                  out_valid,
   output mvt_pkg::sum_arr_type  sum
);

   mvt_pkg::pair_arr_type pair_ff;
   mvt_pkg::pair_arr_type pair_in;
   mvt_pkg::sum_arr_type  sum_ff;
   mvt_pkg::sum_arr_type  sum_in;
   logic                  pair_valid_ff;
   logic                  sum_valid_ff;

   // two registered levels: pairs of products, then the row total
   always_comb begin
      for (int r = 0; r < mvt_pkg::ROWS; r++) begin
         pair_in[r][0] = mvt_pkg::pair_type'(prod[r][0]) + mvt_pkg::pair_type'(prod[r][1]);
         pair_in[r][1] = mvt_pkg::pair_type'(prod[r][2]) + mvt_pkg::pair_type'(prod[r][3]);
         sum_in[r]     = mvt_pkg::sum_type'(pair_ff[r][0]) + mvt_pkg::sum_type'(pair_ff[r][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= in_valid;
         sum_valid_ff  <= pair_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
   end

   assign out_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

// ----- src/mvt_sat.sv -----
`timescale 1ns / 1ps
module mvt_sat (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  mvt_pkg::sum_arr_type sum,
   output logic                 out_valid,
   output mvt_pkg::row_type     res,
   output logic                 saturated
);

   localparam int TOP = mvt_pkg::SUM_W - 1;

   mvt_pkg::sum_type shifted [mvt_pkg::ROWS];
   mvt_pkg::row_type res_ff;
   mvt_pkg::row_type res_in;
   logic [mvt_pkg::ROWS-1:0] clip_hi;
   logic [mvt_pkg::ROWS-1:0] clip_lo;
   logic             sat_ff;
   logic             valid_ff;

   // floor shift, then clip when the bits above 31 are not all the sign
   always_comb begin
      for (int r = 0; r < mvt_pkg::ROWS; r++) begin
         shifted[r] = sum[r] >>> mvt_pkg::FRAC_BITS;
         clip_hi[r] = !shifted[r][TOP] && (|shifted[r][TOP-1:mvt_pkg::DATA_W-1]);
         clip_lo[r] = shifted[r][TOP] && !(&shifted[r][TOP-1:mvt_pkg::DATA_W-1]);
         if (clip_hi[r]) begin
            res_in[r] = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
         end else if (clip_lo[r]) begin
            res_in[r] = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};
         end else begin
            res_in[r] = shifted[r][mvt_pkg::DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sat_ff <= |(clip_hi | clip_lo);
   end

   assign out_valid = valid_ff;
   assign res       = res_ff;
   assign saturated = sat_ff;

endmodule

// ----- src/mat4_vector_transform.sv -----
`timescale 1ns / 1ps
// 4x4 matrix times 4-vector, signed q16.16, saturated rows
// a vector taken at a clock edge passes four register stages (multiply, pair add, row add,
//   shift/saturate) before it shows on the rsp_ ports
// throughput: one vector per cycle; busy stays low, so start may be high every cycle
// reset: synchronous, active high; clears the stage valid bits and the matrix to zero
// the receiver cannot stall: each result is on the ports for one cycle under rsp_valid
module mat4_vector_transform (
   input  logic                   clock,
   input  logic                   reset,
   // vector input, transfer on start && !busy
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_vec_x,
   input  logic signed [31:0]     req_vec_y,
   input  logic signed [31:0]     req_vec_z,
   input  logic signed [31:0]     req_vec_w,
   // result strobe
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_res_x,
   output logic signed [31:0]     rsp_res_y,
   output logic signed [31:0]     rsp_res_z,
   output logic signed [31:0]     rsp_res_w,
   output logic                   rsp_saturated,
   // matrix word writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_data
);

   mvt_pkg::matrix_type   matrix;
   mvt_pkg::vec_type      vec;
   mvt_pkg::prod_arr_type prod;
   mvt_pkg::sum_arr_type  sum;
   mvt_pkg::row_type      res;
   logic                  accept;
   logic                  prod_valid;
   logic                  sum_valid;

   // nothing ever backs up: the pipe advances every cycle
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   // matrix words, held as eight 64-bit registers
   mvt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (mvt_pkg::csr_index_type'(csr_index)),
      .wr_data  (csr_data),
      .matrix   (matrix)
   );

   // stage 1: sixteen products straight off the request ports
   mvt_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .vec       (vec),
      .matrix    (matrix),
      .out_valid (prod_valid),
      .prod      (prod)
   );

   // stages 2 and 3: exact 66-bit row sums, no wrap
   mvt_add_tree u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .prod      (prod),
      .out_valid (sum_valid),
      .sum       (sum)
   );

   // stage 4: arithmetic shift by the fraction width, clip to 32 bits
   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .sum       (sum),
      .out_valid (rsp_valid),
      .res       (res),
      .saturated (rsp_saturated)
   );

   assign rsp_res_x = res[0];
   assign rsp_res_y = res[1];
   assign rsp_res_z = res[2];
   assign rsp_res_w = res[3];

endmodule
